>>> sv/iprt_pkg.sv
// ----------------------------------------------------------------------------
// iprt_pkg
// Shared types and codes for the IP fragment reassembly tracker.
// ----------------------------------------------------------------------------
package iprt_pkg;

	localparam int DEF_TABLE_ENTRIES = 16;

	localparam int CNT_W    = 16;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 4;

	localparam logic CMD_FRAG    = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [15:0] frag_id;
		logic [15:0] src_addr;
		logic [15:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  proto;
	} flow_key_t;

endpackage

>>> sv/iprt_match.sv
// ----------------------------------------------------------------------------
// iprt_match
// Parallel key match over all table slots plus lowest free slot search.
// ----------------------------------------------------------------------------
module iprt_match #(
	parameter int TABLE_ENTRIES = iprt_pkg::DEF_TABLE_ENTRIES,
	parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic [TABLE_ENTRIES-1:0] entry_valid,
	input  iprt_pkg::flow_key_t      entry_key [TABLE_ENTRIES],
	input  iprt_pkg::flow_key_t      search_key,
	output logic                     hit,
	output logic [IDX_W-1:0]         hit_idx,
	output logic                     free_found,
	output logic [IDX_W-1:0]         free_idx
);

	logic [TABLE_ENTRIES-1:0] match_vec;

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			match_vec[i] = entry_valid[i] && (entry_key[i] == search_key);
		end
	end

	// lowest index wins
	always_comb begin
		hit        = 1'b0;
		hit_idx    = '0;
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!entry_valid[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

endmodule

>>> sv/ip_fragment_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// ip_fragment_reassembly_tracker
// Flow table for IP fragment reassembly: key match, slot allocation, byte
// accounting and completion report; release frees a slot.
// ----------------------------------------------------------------------------
//  channel | valid      | stall      | payload
//  --------+------------+------------+------------------------------------------
//  frag    | frag_valid | frag_stall | cmd, flow key, frag_offset/size, more_frags
//  result  | res_valid  | res_stall  | status, was_hit, entry_index, complete,
//          |            |            | total_bytes
//
// One item per cycle unless the result stalls; an item is held in the input
// register, and its result is registered in the result register.
// The table lookup and update are one pass between those two registers.
// Reset clears the slot valid bits; no clearing pass is needed.
// A stalled result holds; the input register fills behind it, then frag_stall.
// ----------------------------------------------------------------------------
module ip_fragment_reassembly_tracker #(
	parameter int TABLE_ENTRIES = iprt_pkg::DEF_TABLE_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        frag_valid,
	output logic        frag_stall,
	input  logic        cmd,
	input  logic [15:0] frag_id,
	input  logic [15:0] src_addr,
	input  logic [15:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [7:0]  proto,
	input  logic [15:0] frag_offset,
	input  logic [15:0] frag_size,
	input  logic        more_frags,

	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  status,
	output logic        was_hit,
	output logic [3:0]  entry_index,
	output logic        complete,
	output logic [15:0] total_bytes
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW    = iprt_pkg::CNT_W;

	// input register
	logic                v_s1;
	logic                cmd_s1;
	iprt_pkg::flow_key_t key_s1;
	logic [CW-1:0]       off_s1;
	logic [CW-1:0]       size_s1;
	logic                mf_s1;

	// table
	logic [TABLE_ENTRIES-1:0] entry_valid_q;
	iprt_pkg::flow_key_t      entry_key_q [TABLE_ENTRIES];
	logic [CW-1:0]            rcv_q [TABLE_ENTRIES];
	logic [CW-1:0]            exp_q [TABLE_ENTRIES];

	logic             adv;
	logic             hit;
	logic [IDX_W-1:0] hit_idx;
	logic             free_found;
	logic [IDX_W-1:0] free_idx;

	logic             slot_ok;
	logic [IDX_W-1:0] slot;
	logic [CW-1:0]    old_rcv;
	logic [CW-1:0]    old_exp;
	logic [CW-1:0]    new_rcv;
	logic [CW-1:0]    new_exp;
	logic [IDX_W+3:0] idx_ext;

	logic [iprt_pkg::STATUS_W-1:0] status_d;
	logic                          hit_d;
	logic [3:0]                    index_d;
	logic                          done_d;
	logic [CW-1:0]                 total_d;

	assign adv        = v_s1 && (!res_valid || !res_stall);
	assign frag_stall = v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!frag_stall) begin
			v_s1 <= frag_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frag_valid && !frag_stall) begin
			cmd_s1  <= cmd;
			key_s1  <= '{frag_id: frag_id, src_addr: src_addr, dst_addr: dst_addr,
			             src_port: src_port, dst_port: dst_port, proto: proto};
			off_s1  <= frag_offset;
			size_s1 <= frag_size;
			mf_s1   <= more_frags;
		end
	end

	iprt_match #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IDX_W        (IDX_W)
	) u_match (
		.entry_valid(entry_valid_q),
		.entry_key  (entry_key_q),
		.search_key (key_s1),
		.hit        (hit),
		.hit_idx    (hit_idx),
		.free_found (free_found),
		.free_idx   (free_idx)
	);

	always_comb begin
		slot    = hit ? hit_idx : free_idx;
		slot_ok = hit || free_found;
		old_rcv = hit ? rcv_q[hit_idx] : '0;
		old_exp = hit ? exp_q[hit_idx] : '0;
		new_rcv = old_rcv + size_s1;
		new_exp = mf_s1 ? old_exp : CW'(off_s1 + size_s1 - old_exp);

		status_d = iprt_pkg::ST_OK;
		hit_d    = 1'b0;
		idx_ext  = '0;
		done_d   = 1'b0;
		total_d  = '0;
		if (cmd_s1 == iprt_pkg::CMD_FRAG) begin
			if (slot_ok) begin
				hit_d   = hit;
				idx_ext = {4'b0000, slot};
				done_d  = (new_exp != '0) && (new_rcv == new_exp);
				total_d = new_exp;
			end else begin
				status_d = iprt_pkg::ST_FULL;
			end
		end else begin
			if (hit) begin
				hit_d   = 1'b1;
				idx_ext = {4'b0000, hit_idx};
				total_d = old_exp;
			end else begin
				status_d = iprt_pkg::ST_NOT_FOUND;
			end
		end
		index_d = idx_ext[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			res_valid     <= 1'b0;
		end else begin
			if (adv) begin
				if (cmd_s1 == iprt_pkg::CMD_FRAG) begin
					if (slot_ok) begin
						entry_valid_q[slot] <= 1'b1;
					end
				end else if (hit) begin
					entry_valid_q[hit_idx] <= 1'b0;
				end
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if ((cmd_s1 == iprt_pkg::CMD_FRAG) && slot_ok) begin
				entry_key_q[slot] <= key_s1;
				rcv_q[slot]       <= new_rcv;
				exp_q[slot]       <= new_exp;
			end
			status      <= status_d;
			was_hit     <= hit_d;
			entry_index <= index_d;
			complete    <= done_d;
			total_bytes <= total_d;
		end
	end

	// ------------------------------------------------------------------------
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == iprt_pkg::ST_FULL) |-> !was_hit && !complete &&
		(total_bytes == '0))
		else $error("full result carries slot data");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && complete |-> (total_bytes != '0) && (status == iprt_pkg::ST_OK))
		else $error("complete with zero total or bad status");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && (cmd_s1 == iprt_pkg::CMD_RELEASE) && hit |=>
		!entry_valid_q[$past(hit_idx)])
		else $error("released slot still valid");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && (cmd_s1 == iprt_pkg::CMD_FRAG) && !hit && free_found |=>
		entry_valid_q[$past(free_idx)])
		else $error("allocated slot not valid");

endmodule

>>> verif/ip_fragment_reassembly_tracker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_fragment_reassembly_tracker_test
// Drives fragment and release items into the flow table and checks every
// result against a flow table model kept in the bench. A short directed run
// covers the field extremes, completion on the first fragment, release hit
// and miss, and a full table. Then come interleaved datagrams, some with shuffled
// fragments, with noise, dropped and repeated fragments, near-miss keys
// and flows that are never released. Both sides idle at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module ip_fragment_reassembly_tracker_test;

	localparam int TABLE_ENTRIES = iprt_pkg::DEF_TABLE_ENTRIES;
	localparam int ITEM_COUNT    = 900;
	localparam int MAX_OPEN      = 20;
	localparam int MAX_FRAGS     = 4;
	localparam int QUIET_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 60;

	typedef struct packed {
		logic                cmd;
		iprt_pkg::flow_key_t key;
		logic [15:0]         offset;
		logic [15:0]         size;
		logic                more;
	} frag_item_t;

	typedef struct packed {
		logic [1:0]  st;
		logic        hit;
		logic [3:0]  slot;
		logic        done;
		logic [15:0] total_len;
	} frag_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        frag_valid = 1'b0;
	logic        frag_stall;
	logic        cmd = iprt_pkg::CMD_FRAG;
	logic [15:0] frag_id = '0;
	logic [15:0] src_addr = '0;
	logic [15:0] dst_addr = '0;
	logic [15:0] src_port = '0;
	logic [15:0] dst_port = '0;
	logic [7:0]  proto = '0;
	logic [15:0] frag_offset = '0;
	logic [15:0] frag_size = '0;
	logic        more_frags = 1'b0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [1:0]  status;
	logic        was_hit;
	logic [3:0]  entry_index;
	logic        complete;
	logic [15:0] total_bytes;

	ip_fragment_reassembly_tracker #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// flow table model
	logic                flow_live  [TABLE_ENTRIES];
	iprt_pkg::flow_key_t flow_key   [TABLE_ENTRIES];
	logic [15:0]         flow_rcvd  [TABLE_ENTRIES];
	logic [15:0]         flow_total [TABLE_ENTRIES];

	frag_item_t   send_q[$];
	frag_result_t expected_q[$];
	frag_item_t   cur_item;

	int n_offered = 0;
	int n_taken = 0;
	int n_total = 0;
	int n_res = 0;
	int n_errors = 0;
	int n_done = 0;
	int n_full = 0;
	int n_lost = 0;
	int n_hits = 0;
	int hold_cycles = 0;
	bit held_once = 1'b0;
	int quiet_cycles = 0;

	function automatic frag_result_t track_item(frag_item_t it);
		frag_result_t r;
		int s;
		r = '0;
		s = -1;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
			if (flow_live[i] && flow_key[i] == it.key) s = i;
		if (it.cmd == iprt_pkg::CMD_FRAG) begin
			if (s >= 0) r.hit = 1'b1;
			else begin
				for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
					if (!flow_live[i]) s = i;
				if (s >= 0) begin
					flow_live[s]  = 1'b1;
					flow_key[s]   = it.key;
					flow_rcvd[s]  = '0;
					flow_total[s] = '0;
				end
			end
			if (s < 0) r.st = iprt_pkg::ST_FULL;
			else begin
				flow_rcvd[s] = flow_rcvd[s] + it.size;
				if (!it.more) flow_total[s] = it.offset + it.size - flow_total[s];
				r.slot      = 4'(s);
				r.done      = flow_total[s] != '0 && flow_rcvd[s] == flow_total[s];
				r.total_len = flow_total[s];
			end
		end else if (s < 0) r.st = iprt_pkg::ST_NOT_FOUND;
		else begin
			r.hit        = 1'b1;
			r.slot       = 4'(s);
			r.total_len  = flow_total[s];
			flow_live[s] = 1'b0;
		end
		return r;
	endfunction

	function automatic iprt_pkg::flow_key_t rand_key();
		iprt_pkg::flow_key_t k;
		k.frag_id  = 16'($urandom);
		k.src_addr = 16'($urandom);
		k.dst_addr = 16'($urandom);
		k.src_port = 16'($urandom);
		k.dst_port = 16'($urandom);
		k.proto    = 8'($urandom);
		return k;
	endfunction

	task automatic queue_item(logic c, iprt_pkg::flow_key_t k, logic [15:0] off,
			logic [15:0] sz, logic mf);
		frag_item_t it;
		it.cmd    = c;
		it.key    = k;
		it.offset = off;
		it.size   = sz;
		it.more   = mf;
		send_q.push_back(it);
	endtask

	task automatic report(string what);
		n_errors++;
		if (n_errors <= 10) $display("%s", what);
	endtask

	// sender
	always @(negedge clk) begin : drive_items
		logic go;
		go = 1'b0;
		if (arst_n && n_offered == n_taken) begin
			if (send_q.size() != 0)
				go = (n_offered >= 400 && n_offered < 550) || $urandom_range(0, 99) >= 30;
			if (go) begin
				cur_item = send_q.pop_front();
				n_offered++;
				cmd         <= cur_item.cmd;
				frag_id     <= cur_item.key.frag_id;
				src_addr    <= cur_item.key.src_addr;
				dst_addr    <= cur_item.key.dst_addr;
				src_port    <= cur_item.key.src_port;
				dst_port    <= cur_item.key.dst_port;
				proto       <= cur_item.key.proto;
				frag_offset <= cur_item.offset;
				frag_size   <= cur_item.size;
				more_frags  <= cur_item.more;
			end
			frag_valid <= go;
		end
	end

	// receiver
	always @(negedge clk) begin : drive_stall
		logic hold;
		if (hold_cycles > 0) begin
			hold_cycles--;
			hold = 1'b1;
		end else if (!held_once && n_res >= 200) begin
			held_once = 1'b1;
			hold_cycles = HOLD_CYCLES;
			hold = 1'b1;
		end else
			hold = !(n_res >= 450 && n_res < 600) && $urandom_range(0, 99) < 30;
		res_stall <= hold;
	end

	// prediction and checking
	always @(posedge clk) begin : check_results
		frag_result_t want;
		if (arst_n && frag_valid && !frag_stall) begin
			expected_q.push_back(track_item(cur_item));
			n_taken++;
		end
		if (arst_n && res_valid && !res_stall) begin
			n_res++;
			if (expected_q.size() == 0)
				report($sformatf("result %0d with nothing expected: st=%0d hit=%0d slot=%0d",
					n_res, status, was_hit, entry_index));
			else begin
				want = expected_q.pop_front();
				if (status != want.st || was_hit != want.hit || entry_index != want.slot ||
						complete != want.done || total_bytes != want.total_len)
					report($sformatf({"result %0d mismatch: exp st=%0d hit=%0d slot=%0d ",
						"done=%0d total=%h, got st=%0d hit=%0d slot=%0d done=%0d total=%h"},
						n_res, want.st, want.hit, want.slot, want.done, want.total_len,
						status, was_hit, entry_index, complete, total_bytes));
				if (want.st == iprt_pkg::ST_FULL) n_full++;
				if (want.st == iprt_pkg::ST_NOT_FOUND) n_lost++;
				if (want.done) n_done++;
				if (want.hit) n_hits++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((frag_valid && !frag_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		iprt_pkg::flow_key_t k0, kf, ka, k;
		iprt_pkg::flow_key_t leaked[$];
		iprt_pkg::flow_key_t dg_key  [MAX_OPEN];
		int                  dg_n    [MAX_OPEN];
		int                  dg_next [MAX_OPEN];
		logic [15:0]         dg_off  [MAX_OPEN][MAX_FRAGS];
		logic [15:0]         dg_size [MAX_OPEN][MAX_FRAGS];
		logic                dg_more [MAX_OPEN][MAX_FRAGS];
		logic [15:0]         pos, t16;
		logic                t1;
		int                  n_open, r, j, w, nf;

		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			flow_live[i]  = 1'b0;
			flow_key[i]   = '0;
			flow_rcvd[i]  = '0;
			flow_total[i] = '0;
		end

		// directed
		k0 = '0;
		kf = '1;
		ka = iprt_pkg::flow_key_t'({16'h0001, 16'h0a00, 16'h0a01, 16'd4000, 16'd80, 8'd17});
		queue_item(iprt_pkg::CMD_FRAG, k0, 16'h0000, 16'h0000, 1'b0);
		queue_item(iprt_pkg::CMD_FRAG, k0, 16'h0000, 16'h0000, 1'b1);
		queue_item(iprt_pkg::CMD_FRAG, kf, 16'hFFFF, 16'hFFFF, 1'b1);
		queue_item(iprt_pkg::CMD_FRAG, kf, 16'h0000, 16'h0001, 1'b0);
		queue_item(iprt_pkg::CMD_FRAG, kf, 16'h0002, 16'hFFFF, 1'b0);
		queue_item(iprt_pkg::CMD_FRAG, ka, 16'h0000, 16'd100, 1'b0);
		queue_item(iprt_pkg::CMD_RELEASE, ka, '0, '0, 1'b0);
		queue_item(iprt_pkg::CMD_RELEASE, ka, '0, '0, 1'b0);
		queue_item(iprt_pkg::CMD_RELEASE, k0, '1, '1, 1'b1);
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			k = ka;
			k.frag_id = 16'(100 + i);
			queue_item(iprt_pkg::CMD_FRAG, k, '0, 16'(8 * i), 1'b1);
			leaked.push_back(k);
		end
		leaked.push_back(kf);

		// random datagrams, interleaved
		n_open = 0;
		while (send_q.size() < ITEM_COUNT) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				k = (n_open > 0 && $urandom_range(0, 1)) ? dg_key[$urandom_range(0, n_open - 1)]
					: rand_key();
				t1 = 1'($urandom);
				queue_item(t1, k, 16'($urandom), 16'($urandom), 1'($urandom));
				if (t1 == iprt_pkg::CMD_FRAG) leaked.push_back(k);
			end else if (r < 14 && leaked.size() != 0) begin
				j = $urandom_range(0, leaked.size() - 1);
				queue_item(iprt_pkg::CMD_RELEASE, leaked[j], '0, '0, 1'b0);
				leaked.delete(j);
			end else if ((r < 30 || n_open == 0) && n_open < MAX_OPEN) begin
				if (n_open > 0 && $urandom_range(0, 4) == 0)
					dg_key[n_open] = iprt_pkg::flow_key_t'(
						dg_key[$urandom_range(0, n_open - 1)] ^
						(88'd1 << $urandom_range(0, 87)));
				else
					dg_key[n_open] = rand_key();
				nf = $urandom_range(1, MAX_FRAGS);
				pos = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h0000;
				for (int f = 0; f < nf; f++) begin
					t16 = ($urandom_range(0, 9) == 0) ? 16'($urandom)
						: 16'($urandom_range(1, 1500));
					dg_off[n_open][f]  = pos;
					dg_size[n_open][f] = t16;
					dg_more[n_open][f] = (f != nf - 1);
					pos = pos + t16;
				end
				if ($urandom_range(0, 1))
					for (int f = nf - 1; f > 0; f--) begin
						w = $urandom_range(0, f);
						t16 = dg_off[n_open][f];
						dg_off[n_open][f] = dg_off[n_open][w];
						dg_off[n_open][w] = t16;
						t16 = dg_size[n_open][f];
						dg_size[n_open][f] = dg_size[n_open][w];
						dg_size[n_open][w] = t16;
						t1 = dg_more[n_open][f];
						dg_more[n_open][f] = dg_more[n_open][w];
						dg_more[n_open][w] = t1;
					end
				// lost fragment: the datagram never completes
				if (nf > 1 && $urandom_range(0, 9) == 0) nf--;
				dg_n[n_open] = nf;
				dg_next[n_open] = 0;
				n_open++;
			end else if (n_open > 0) begin
				j = $urandom_range(0, n_open - 1);
				w = dg_next[j];
				queue_item(iprt_pkg::CMD_FRAG, dg_key[j], dg_off[j][w], dg_size[j][w],
					dg_more[j][w]);
				if ($urandom_range(0, 29) != 0) dg_next[j]++;
				if (dg_next[j] == dg_n[j]) begin
					if ($urandom_range(0, 9) != 0)
						queue_item(iprt_pkg::CMD_RELEASE, dg_key[j], '0, '0, 1'b0);
					else leaked.push_back(dg_key[j]);
					n_open--;
					dg_key[j]  = dg_key[n_open];
					dg_n[j]    = dg_n[n_open];
					dg_next[j] = dg_next[n_open];
					dg_off[j]  = dg_off[n_open];
					dg_size[j] = dg_size[n_open];
					dg_more[j] = dg_more[n_open];
				end
			end
		end
		n_total = send_q.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_taken < n_total || expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d items sent, %0d results checked", n_taken, n_res);
		$display("%0d completions, %0d hits, %0d table full, %0d release misses",
			n_done, n_hits, n_full, n_lost);
		if (n_errors == 0 && expected_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
sv/iprt_pkg.sv
sv/iprt_match.sv
sv/ip_fragment_reassembly_tracker.sv
verif/ip_fragment_reassembly_tracker_test.sv
